// ===== src/periodic_unwrap_msd_top_macros.svh =====
// assertion macros for the msd block
`ifndef PERIODIC_UNWRAP_MSD_TOP_MACROS_SVH
`define PERIODIC_UNWRAP_MSD_TOP_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define PUM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication checked on every rising clock edge outside reset
`define PUM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/pum_pkg.sv =====
package pum_pkg;

   localparam int unsigned POS_W = 32;
   localparam int unsigned BOX_W = 31;
   localparam int unsigned CNT_W = 11;
   localparam int unsigned FRM_W = 16;
   localparam int unsigned WRP_W = 16;
   localparam int unsigned ACC_W = 64;
   localparam int unsigned OUT_W = 32;
   localparam int unsigned IDX_W = 3;

   localparam logic [IDX_W-1:0] REG_BOX_X = 3'd0;
   localparam logic [IDX_W-1:0] REG_BOX_Y = 3'd1;
   localparam logic [IDX_W-1:0] REG_BOX_Z = 3'd2;
   localparam logic [IDX_W-1:0] REG_COUNT = 3'd3;
   localparam logic [IDX_W-1:0] REG_START = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_WAIT,
      ST_DIV,
      ST_WRAP,
      ST_DISP,
      ST_SQ,
      ST_ACC,
      ST_WRITE,
      ST_ODIV,
      ST_OUT
   } state_type;

   // divider operation request
   typedef struct packed {
      logic        start;
      logic [63:0] num;
      logic [63:0] den;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] quo;
   } div_rsp_type;

   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
      logic [ACC_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
   endfunction

endpackage

// ===== src/pum_if.sv =====
interface pum_req_if;
   logic                         valid;
   logic                         ready;
   logic signed [pum_pkg::POS_W-1:0] pos_x;
   logic signed [pum_pkg::POS_W-1:0] pos_y;
   logic signed [pum_pkg::POS_W-1:0] pos_z;
   modport source (output valid, pos_x, pos_y, pos_z, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface pum_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pum_pkg::FRM_W-1:0]    frame_index;
   logic [pum_pkg::OUT_W-1:0]    msd_x;
   logic [pum_pkg::OUT_W-1:0]    msd_y;
   logic [pum_pkg::OUT_W-1:0]    msd_z;
   logic [pum_pkg::OUT_W-1:0]    msd_total;
   modport source (output valid, frame_index, msd_x, msd_y, msd_z, msd_total,
                   input ready);
   modport sink (input valid, frame_index, msd_x, msd_y, msd_z, msd_total,
                 output ready);
endinterface

interface pum_csr_if;
   logic                         valid;
   logic                         ready;
   logic [pum_pkg::IDX_W-1:0]    index;
   logic [31:0]                  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== src/pum_div.sv =====
module pum_div (
   input  logic                  clock,
   input  logic                  reset,
   input  pum_pkg::div_req_type  req,
   output pum_pkg::div_rsp_type  rsp
);

   logic [63:0] quo_ff, quo_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;
   logic [64:0] shifted;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[63]};
      trial   = shifted - {1'b0, den_ff};
      if (req.start) begin
         quo_in  = req.num;
         rem_in  = '0;
         den_in  = req.den;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one quotient bit a cycle
         if (!trial[64]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted[63:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule

// ===== src/pum_mem.sv =====
module pum_mem #(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

// ===== src/periodic_unwrap_msd_top.sv =====
// Periodic-box mean squared displacement with boundary unwrapping. Positions
// (signed Q16.16) arrive one beat per particle, frame after frame; frames
// before start_frame are ignored and the start frame stores each particle's
// reference. On the last particle of each frame from start_frame on one
// result beat gives the x, y, z and total squared displacement sums divided
// by twice the particle count, Q16.16, saturating. Each item is handled
// alone: a particle after the start frame goes through one shared 64-step
// restoring divider and one 24x24 multiplier used three times per square,
// with a read-modify-write of the per-particle memories. A frame's last
// particle adds the four output divisions, and the next beat is taken only
// once the result beat has left. References, previous positions and crossing
// counts of a slot must be written in the start frame before any later frame
// reads them; the user is bound to this, the block itself does not enforce it.
`include "periodic_unwrap_msd_top_macros.svh"

module periodic_unwrap_msd_top #(
   parameter int unsigned MAX_PARTICLES = 1024
) (
   input  logic      clock,
   input  logic      reset,
   pum_req_if.sink   req,
   pum_rsp_if.source rsp,
   pum_csr_if.sink   csr
);

   localparam int unsigned AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
   localparam int unsigned MW = 3 * pum_pkg::POS_W;
   localparam int unsigned WW = 3 * pum_pkg::WRP_W;

   pum_pkg::state_type state_ff, state_in;

   logic [pum_pkg::BOX_W-1:0] box_ff [3];
   logic [pum_pkg::CNT_W-1:0] count_ff;
   logic [pum_pkg::FRM_W-1:0] start_ff;
   logic [AW:0]               slot_ff, slot_in;
   logic [pum_pkg::FRM_W-1:0] frame_ff, frame_in;
   logic [pum_pkg::ACC_W-1:0] acc_ff [4];
   logic [pum_pkg::ACC_W-1:0] acc_in [4];

   logic signed [pum_pkg::POS_W-1:0] pos_ff [3];
   logic [1:0]  axis_ff, axis_in;
   logic [pum_pkg::WRP_W-1:0] wraps_ff [3];
   logic [pum_pkg::WRP_W-1:0] wraps_in [3];
   logic [pum_pkg::ACC_W-1:0] term_ff [3];
   logic [pum_pkg::ACC_W-1:0] term_in [3];
   logic signed [63:0] d_ff, d_in;
   logic [63:0]        prod_ff, prod_in;
   logic               neg_ff, neg_in;
   logic [pum_pkg::OUT_W-1:0] res_ff [4];
   logic [pum_pkg::OUT_W-1:0] res_in [4];
   logic [pum_pkg::FRM_W-1:0] rframe_ff, rframe_in;
   logic                      rvalid_ff, rvalid_in;
   logic [1:0]  sub_ff, sub_in;

   pum_pkg::div_req_type dreq;
   pum_pkg::div_rsp_type drsp;

   logic          mem_we;
   logic [AW-1:0] addr;
   logic [MW-1:0] ref_wd, ref_rd, prev_wd, prev_rd;
   logic [WW-1:0] wr_wd, wr_rd;

   logic [pum_pkg::CNT_W-1:0] n_eff;
   logic active, is_start, in_range, last;
   logic [pum_pkg::BOX_W-1:0] box_cur;
   logic signed [pum_pkg::POS_W-1:0] prev_cur, ref_cur;
   logic signed [pum_pkg::WRP_W-1:0] wr_cur;
   logic signed [33:0] step;
   logic [33:0] step_mag;
   logic signed [pum_pkg::WRP_W+1:0] wnew;
   logic signed [63:0] bw_prod;
   logic [63:0] dmag;
   logic        dsat;
   logic [23:0] mul_a, mul_b;
   logic [47:0] mul_p;
   logic [pum_pkg::ACC_W-1:0] tsum;

   assign addr = slot_ff[AW-1:0];

   pum_mem #(.DEPTH(MAX_PARTICLES), .WIDTH(MW)) u_ref (
      .clock, .wr_en(mem_we && is_start), .wr_addr(addr), .wr_data(ref_wd),
      .rd_addr(addr), .rd_data(ref_rd));
   pum_mem #(.DEPTH(MAX_PARTICLES), .WIDTH(MW)) u_prev (
      .clock, .wr_en(mem_we), .wr_addr(addr), .wr_data(prev_wd),
      .rd_addr(addr), .rd_data(prev_rd));
   pum_mem #(.DEPTH(MAX_PARTICLES), .WIDTH(WW)) u_wraps (
      .clock, .wr_en(mem_we), .wr_addr(addr), .wr_data(wr_wd),
      .rd_addr(addr), .rd_data(wr_rd));

   pum_div u_div (.clock, .reset, .req(dreq), .rsp(drsp));

   always_comb begin
      if (count_ff == '0) begin
         n_eff = pum_pkg::CNT_W'(1);
      end else if ({21'd0, count_ff} > MAX_PARTICLES) begin
         n_eff = pum_pkg::CNT_W'(MAX_PARTICLES);
      end else begin
         n_eff = count_ff;
      end
   end

   assign active   = frame_ff >= start_ff;
   assign is_start = frame_ff == start_ff;
   assign in_range = {21'd0, slot_ff} < MAX_PARTICLES;
   assign last     = ({21'd0, slot_ff} + 32'd1) >= {21'd0, n_eff};

   assign ref_wd  = {pos_ff[2], pos_ff[1], pos_ff[0]};
   assign prev_wd = {pos_ff[2], pos_ff[1], pos_ff[0]};
   assign wr_wd   = {wraps_ff[2], wraps_ff[1], wraps_ff[0]};

   always_comb begin
      box_cur  = box_ff[axis_ff];
      if (box_cur == '0) begin
         box_cur = pum_pkg::BOX_W'(1);
      end
      prev_cur = prev_rd[axis_ff*pum_pkg::POS_W +: pum_pkg::POS_W];
      ref_cur  = is_start ? pos_ff[axis_ff] :
                 ref_rd[axis_ff*pum_pkg::POS_W +: pum_pkg::POS_W];
      wr_cur   = wr_rd[axis_ff*pum_pkg::WRP_W +: pum_pkg::WRP_W];
      step     = 34'(pos_ff[axis_ff]) - 34'(prev_cur);
      step_mag = step[33] ? 34'(-step) : step;
      wnew     = 18'(wr_cur) + (neg_ff ? 18'(drsp.quo[15:0]) : -18'(drsp.quo[15:0]));
      if (drsp.quo[63:16] != '0) begin
         wnew = neg_ff ? 18'sd32767 : -18'sd32768;
      end
      bw_prod  = $signed({33'd0, box_ff[axis_ff]}) * 64'(signed'(wraps_ff[axis_ff]));
      dmag     = d_ff[63] ? 64'(-d_ff) : 64'(d_ff);
      dsat     = dmag[63:40] != '0;
      case (sub_ff)
         2'd0: begin
            mul_a = dmag[39:16];
            mul_b = dmag[39:16];
         end
         2'd1: begin
            mul_a = dmag[39:16];
            mul_b = {8'd0, dmag[15:0]};
         end
         default: begin
            mul_a = {8'd0, dmag[15:0]};
            mul_b = {8'd0, dmag[15:0]};
         end
      endcase
      mul_p    = mul_a * mul_b;
      tsum     = pum_pkg::sat_add(pum_pkg::sat_add(term_ff[0], term_ff[1]), term_ff[2]);
   end

   always_comb begin
      state_in   = state_ff;
      slot_in    = slot_ff;
      frame_in   = frame_ff;
      acc_in     = acc_ff;
      axis_in    = axis_ff;
      wraps_in   = wraps_ff;
      term_in    = term_ff;
      d_in       = d_ff;
      prod_in    = prod_ff;
      neg_in     = neg_ff;
      res_in     = res_ff;
      rframe_in  = rframe_ff;
      rvalid_in  = rvalid_ff;
      sub_in     = sub_ff;
      dreq       = '0;
      mem_we     = 1'b0;
      req.ready  = 1'b0;
      if (rvalid_ff && rsp.ready) begin
         rvalid_in = 1'b0;
      end
      unique case (state_ff)
         pum_pkg::ST_IDLE: begin
            req.ready = !rvalid_ff;
            if (req.valid && !rvalid_ff) begin
               axis_in = '0;
               if (active && in_range) begin
                  state_in = pum_pkg::ST_READ;
               end else begin
                  state_in = pum_pkg::ST_WRITE;
               end
            end
         end
         pum_pkg::ST_READ: begin
            state_in = pum_pkg::ST_WAIT;
         end
         pum_pkg::ST_WAIT: begin
            if (is_start) begin
               wraps_in[axis_ff] = '0;
               state_in = pum_pkg::ST_DISP;
            end else begin
               neg_in   = step[33];
               dreq.start = 1'b1;
               dreq.num = {29'd0, step_mag, 1'b0} + {33'd0, box_cur};
               dreq.den = {32'd0, box_cur, 1'b0};
               state_in = pum_pkg::ST_DIV;
            end
         end
         pum_pkg::ST_DIV: begin
            if (drsp.done) begin
               state_in = pum_pkg::ST_WRAP;
            end
         end
         pum_pkg::ST_WRAP: begin
            if (wnew > 18'sd32767) begin
               wraps_in[axis_ff] = 16'h7fff;
            end else if (wnew < -18'sd32768) begin
               wraps_in[axis_ff] = 16'h8000;
            end else begin
               wraps_in[axis_ff] = wnew[15:0];
            end
            state_in = pum_pkg::ST_DISP;
         end
         pum_pkg::ST_DISP: begin
            d_in     = bw_prod + 64'(pos_ff[axis_ff]) - 64'(ref_cur);
            sub_in   = '0;
            state_in = pum_pkg::ST_SQ;
         end
         pum_pkg::ST_SQ: begin
            // square in three partial products: hi*hi, 2*hi*lo, lo*lo
            case (sub_ff)
               2'd0: prod_in = {mul_p, 16'd0};
               2'd1: prod_in = prod_ff + {15'd0, mul_p, 1'b0};
               default: prod_in = prod_ff + {32'd0, mul_p[47:16]};
            endcase
            if (sub_ff == 2'd2) begin
               state_in = pum_pkg::ST_ACC;
            end else begin
               sub_in = sub_ff + 2'd1;
            end
         end
         pum_pkg::ST_ACC: begin
            term_in[axis_ff] = dsat ? {64{1'b1}} : prod_ff;
            if (axis_ff == 2'd2) begin
               state_in = pum_pkg::ST_WRITE;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = pum_pkg::ST_WAIT;
            end
         end
         pum_pkg::ST_WRITE: begin
            if (active && in_range) begin
               mem_we     = 1'b1;
               acc_in[0] = pum_pkg::sat_add(acc_ff[0], term_ff[0]);
               acc_in[1] = pum_pkg::sat_add(acc_ff[1], term_ff[1]);
               acc_in[2] = pum_pkg::sat_add(acc_ff[2], term_ff[2]);
               acc_in[3] = pum_pkg::sat_add(acc_ff[3], tsum);
            end
            if (last) begin
               slot_in = '0;
               if (frame_ff != '1) begin
                  frame_in = frame_ff + 16'd1;
               end
               if (active) begin
                  rframe_in = frame_ff;
                  sub_in    = '0;
                  state_in  = pum_pkg::ST_ODIV;
                  dreq.start = 1'b1;
                  dreq.num  = acc_in[0];
                  dreq.den  = {52'd0, n_eff, 1'b0};
               end else begin
                  acc_in   = '{default: '0};
                  state_in = pum_pkg::ST_IDLE;
               end
            end else begin
               slot_in  = slot_ff + 1'b1;
               state_in = pum_pkg::ST_IDLE;
            end
         end
         pum_pkg::ST_ODIV: begin
            if (drsp.done) begin
               res_in[sub_ff] = (drsp.quo[63:32] != '0) ? '1 : drsp.quo[31:0];
               if (sub_ff == 2'd3) begin
                  state_in = pum_pkg::ST_OUT;
               end else begin
                  sub_in     = sub_ff + 2'd1;
                  dreq.start = 1'b1;
                  dreq.num   = acc_ff[sub_ff + 2'd1];
                  dreq.den   = {52'd0, n_eff, 1'b0};
               end
            end
         end
         pum_pkg::ST_OUT: begin
            rvalid_in = 1'b1;
            acc_in    = '{default: '0};
            state_in  = pum_pkg::ST_IDLE;
         end
         default: begin
            state_in = pum_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= pum_pkg::ST_IDLE;
         slot_ff   <= '0;
         frame_ff  <= '0;
         acc_ff    <= '{default: '0};
         rvalid_ff <= 1'b0;
         box_ff    <= '{default: pum_pkg::BOX_W'(655360)};
         count_ff  <= pum_pkg::CNT_W'(1024);
         start_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         slot_ff   <= slot_in;
         frame_ff  <= frame_in;
         acc_ff    <= acc_in;
         rvalid_ff <= rvalid_in;
         if (csr.valid) begin
            case (csr.index)
               pum_pkg::REG_BOX_X: box_ff[0] <= csr.data[pum_pkg::BOX_W-1:0];
               pum_pkg::REG_BOX_Y: box_ff[1] <= csr.data[pum_pkg::BOX_W-1:0];
               pum_pkg::REG_BOX_Z: box_ff[2] <= csr.data[pum_pkg::BOX_W-1:0];
               pum_pkg::REG_COUNT: count_ff  <= csr.data[pum_pkg::CNT_W-1:0];
               pum_pkg::REG_START: start_ff  <= csr.data[pum_pkg::FRM_W-1:0];
               default: ;
            endcase
         end
      end
      if (state_ff == pum_pkg::ST_IDLE && req.valid && req.ready) begin
         pos_ff[0] <= req.pos_x;
         pos_ff[1] <= req.pos_y;
         pos_ff[2] <= req.pos_z;
      end
      axis_ff   <= axis_in;
      wraps_ff  <= wraps_in;
      term_ff   <= term_in;
      d_ff      <= d_in;
      prod_ff   <= prod_in;
      neg_ff    <= neg_in;
      res_ff    <= res_in;
      rframe_ff <= rframe_in;
      sub_ff    <= sub_in;
   end

   assign csr.ready       = 1'b1;
   assign rsp.valid       = rvalid_ff;
   assign rsp.frame_index = rframe_ff;
   assign rsp.msd_x       = res_ff[0];
   assign rsp.msd_y       = res_ff[1];
   assign rsp.msd_z       = res_ff[2];
   assign rsp.msd_total   = res_ff[3];

   `PUM_ASSERT_IMP(a_ready_idle, clock, reset, req.ready, state_ff == pum_pkg::ST_IDLE)
   `PUM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.msd_total))
   `PUM_ASSERT_IMP(a_div_idle, clock, reset, drsp.busy, state_ff == pum_pkg::ST_DIV || state_ff == pum_pkg::ST_ODIV)

endmodule

// ===== sim/periodic_unwrap_msd_checker.sv =====
module periodic_unwrap_msd_checker (
   input  logic        clock,
   input  logic        reset,
   pum_req_if          req,
   pum_rsp_if          rsp,
   pum_csr_if          csr,
   output int          fails,
   output int          pending,
   output logic [15:0] frame_now
);

   typedef struct packed {
      logic [pum_pkg::FRM_W-1:0] frame;
      logic [pum_pkg::OUT_W-1:0] x;
      logic [pum_pkg::OUT_W-1:0] y;
      logic [pum_pkg::OUT_W-1:0] z;
      logic [pum_pkg::OUT_W-1:0] total;
   } msd_beat_type;

   msd_beat_type               msd_expected[$];
   logic [pum_pkg::BOX_W-1:0]  side[3];
   logic [pum_pkg::CNT_W-1:0]  count_cfg;
   logic [pum_pkg::FRM_W-1:0]  start_cfg;
   logic [pum_pkg::FRM_W-1:0]  frame_ctr;
   int                         slot;
   longint                     ref_pos[3][1024];
   longint                     prev_pos[3][1024];
   longint                     wraps[3][1024];
   logic [pum_pkg::ACC_W-1:0]  sums[4];

   assign pending   = msd_expected.size();
   assign frame_now = frame_ctr;

   function automatic logic [63:0] sat64(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   // nearest crossing count, halves away from zero
   function automatic longint crossings(longint d, longint box);
      longint mag;
      longint q;
      if (box == 0) box = 1;
      mag = (d < 0) ? -d : d;
      q = (2 * mag + box) / (2 * box);
      return (d < 0) ? -q : q;
   endfunction

   function automatic logic [63:0] square_q16(longint d);
      logic [63:0]  a;
      logic [127:0] p;
      a = (d < 0) ? -d : d;
      if (a >= 64'd1 << 40) return '1;
      p = a * a;
      return p[79:16];
   endfunction

   function automatic logic [31:0] average(logic [63:0] acc, int n);
      logic [63:0] q;
      q = acc / (2 * n);
      return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("msd mismatch %s: got %h expected %h", what, got, want);
      fails++;
   endtask

   task automatic take_particle(logic signed [31:0] px, logic signed [31:0] py,
                                logic signed [31:0] pz);
      int           n;
      bit           active;
      longint       p[3];
      longint       v;
      logic [63:0]  t[3];
      msd_beat_type beat;
      n = (count_cfg < 1) ? 1 : (count_cfg > 1024) ? 1024 : count_cfg;
      active = frame_ctr >= start_cfg;
      p[0] = px;
      p[1] = py;
      p[2] = pz;
      if (active && slot < 1024) begin
         for (int a = 0; a < 3; a++) begin
            if (frame_ctr == start_cfg) begin
               ref_pos[a][slot] = p[a];
               wraps[a][slot]   = 0;
            end else begin
               v = wraps[a][slot] - crossings(p[a] - prev_pos[a][slot], longint'(side[a]));
               if (v > 32767) v = 32767;
               if (v < -32768) v = -32768;
               wraps[a][slot] = v;
            end
            prev_pos[a][slot] = p[a];
            t[a] = square_q16(p[a] + longint'(side[a]) * wraps[a][slot] - ref_pos[a][slot]);
            sums[a] = sat64(sums[a], t[a]);
         end
         sums[3] = sat64(sums[3], sat64(sat64(t[0], t[1]), t[2]));
      end
      if (slot + 1 >= n) begin
         if (active) begin
            beat.frame = frame_ctr;
            beat.x     = average(sums[0], n);
            beat.y     = average(sums[1], n);
            beat.z     = average(sums[2], n);
            beat.total = average(sums[3], n);
            msd_expected.push_back(beat);
         end
         for (int a = 0; a < 4; a++) sums[a] = '0;
         slot = 0;
         if (frame_ctr != 16'hFFFF) frame_ctr++;
      end else begin
         slot++;
      end
   endtask

   always @(posedge clock) begin
      msd_beat_type want;
      if (reset) begin
         side[0] = 31'd655360;
         side[1] = 31'd655360;
         side[2] = 31'd655360;
         count_cfg = 11'd1024;
         start_cfg = '0;
         frame_ctr = '0;
         slot = 0;
         for (int a = 0; a < 4; a++) sums[a] = '0;
         for (int a = 0; a < 3; a++)
            for (int i = 0; i < 1024; i++) wraps[a][i] = 0;
         fails = 0;
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.index)
               pum_pkg::REG_BOX_X: side[0] = csr.data[pum_pkg::BOX_W-1:0];
               pum_pkg::REG_BOX_Y: side[1] = csr.data[pum_pkg::BOX_W-1:0];
               pum_pkg::REG_BOX_Z: side[2] = csr.data[pum_pkg::BOX_W-1:0];
               pum_pkg::REG_COUNT: count_cfg = csr.data[pum_pkg::CNT_W-1:0];
               pum_pkg::REG_START: start_cfg = csr.data[pum_pkg::FRM_W-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) take_particle(req.pos_x, req.pos_y, req.pos_z);
         if (rsp.valid && rsp.ready) begin
            if (msd_expected.size() == 0) begin
               report("unexpected beat", rsp.frame_index, 0);
            end else begin
               want = msd_expected.pop_front();
               if (rsp.frame_index !== want.frame) report("frame_index", rsp.frame_index, want.frame);
               if (rsp.msd_x !== want.x) report("msd_x", rsp.msd_x, want.x);
               if (rsp.msd_y !== want.y) report("msd_y", rsp.msd_y, want.y);
               if (rsp.msd_z !== want.z) report("msd_z", rsp.msd_z, want.z);
               if (rsp.msd_total !== want.total) report("msd_total", rsp.msd_total, want.total);
            end
         end
      end
   end

endmodule

// ===== sim/periodic_unwrap_msd_top_tb.sv =====
module periodic_unwrap_msd_top_tb;

   localparam int CYCLE_LIMIT = 4000000;
   localparam int SETTLE      = 600;

   logic        clock;
   logic        reset;
   int          fails;
   int          pending;
   logic [15:0] frame_now;
   int          cycles = 0;
   int          snd_pct;
   int          rcv_pct;
   int          items;
   int          count_w;
   longint      side_w[3];
   longint      walk[3][8];

   pum_req_if req_ch ();
   pum_rsp_if rsp_ch ();
   pum_csr_if csr_ch ();

   periodic_unwrap_msd_top i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch),
      .csr  (csr_ch)
   );

   periodic_unwrap_msd_checker i_checker (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .rsp      (rsp_ch),
      .csr      (csr_ch),
      .fails    (fails),
      .pending  (pending),
      .frame_now(frame_now)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("periodic_unwrap_msd_top_tb NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= rcv_pct);
   end

   task automatic send(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      while ($urandom_range(99) < snd_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.pos_x <= px;
      req_ch.pos_y <= py;
      req_ch.pos_z <= pz;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items++;
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [pum_pkg::IDX_W-1:0] idx, logic [31:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      if (idx == pum_pkg::REG_BOX_X) side_w[0] = (value[30:0] == 0) ? 1 : value[30:0];
      if (idx == pum_pkg::REG_BOX_Y) side_w[1] = (value[30:0] == 0) ? 1 : value[30:0];
      if (idx == pum_pkg::REG_BOX_Z) side_w[2] = (value[30:0] == 0) ? 1 : value[30:0];
      if (idx == pum_pkg::REG_COUNT) count_w = int'(value[10:0]);
   endtask

   function automatic logic [31:0] pick_box();
      case ($urandom_range(5))
         0: return {1'($urandom_range(1)), 31'd1};
         1: return {1'($urandom_range(1)), 31'd0};
         2: return {1'($urandom_range(1)), 31'h7FFF_FFFF};
         3: return $urandom;
         default: return 32'd65536 * $urandom_range(1, 100);
      endcase
   endfunction

   // next position of one particle on one axis: a random walk folded into the box, or sometimes a random 32-bit value
   function automatic longint step_pos(longint p, longint box);
      longint lim;
      longint mag;
      logic [31:0] r;
      if ($urandom_range(99) < 15) begin
         r = $urandom;
         return longint'($signed(r));
      end
      lim = box + box / 2;
      mag = $urandom_range(0, lim[31:0]);
      p = $urandom_range(1) ? p + mag : p - mag;
      if (p >= box) p -= box;
      if (p < 0) p += box;
      r = p[31:0];
      return longint'($signed(r));
   endfunction

   initial begin
      int n_eff;
      int frames;
      logic [3:0] order;
      items = 0;
      count_w = 1024;
      snd_pct = 32;
      rcv_pct = 75;
      side_w[0] = 655360;
      side_w[1] = 655360;
      side_w[2] = 655360;
      req_ch.valid = 1'b0;
      req_ch.pos_x = '0;
      req_ch.pos_y = '0;
      req_ch.pos_z = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data  = '0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: one ignored frame, then a start frame and two frames of extremes
      write_reg(pum_pkg::REG_BOX_X, 32'd655360);
      write_reg(pum_pkg::REG_BOX_Y, 32'hFFFF_FFFF);
      write_reg(pum_pkg::REG_BOX_Z, 32'd0);
      write_reg(pum_pkg::REG_COUNT, 32'd3);
      write_reg(pum_pkg::REG_START, 32'd1);
      send(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      send(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
      send(32'h0, 32'h0, 32'h5555_AAAA);
      send(32'h0, 32'h0, 32'h0);
      send(32'h7FFF_FFFF, 32'h8000_0000, 32'h1);
      send(32'hFFFF_FFFF, 32'd12345, 32'h8000_0000);
      send(32'd327680, -32'sd327680, 32'h0010_0000);
      send(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send(-32'sd327681, 32'h8000_0000, 32'h0);
      send(32'd983040, 32'hC000_0000, 32'hAAAA_5555);
      send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      settle();

      // count above the maximum, then lowered while the frame is under way
      write_reg(pum_pkg::REG_BOX_X, 32'h7FFF_FFFF);
      write_reg(pum_pkg::REG_COUNT, 32'd2047);
      write_reg(pum_pkg::REG_START, {16'd0, frame_now});
      send(32'd100, 32'd200, 32'd300);
      send(32'hFFFF_0000, 32'd65536, 32'h8000_0000);
      send(32'h4000_0000, 32'hBFFF_FFFF, 32'd7);
      settle();
      write_reg(pum_pkg::REG_COUNT, 32'd3);
      send(32'd1, 32'd2, 32'd3);
      send(32'd500, 32'h7000_0000, 32'hF000_0000);
      send(32'h8000_0001, 32'd0, 32'd65536);
      send(32'd300, 32'd300, 32'd300);

      while (items < 680) begin
         settle();
         if (items >= 500) begin
            snd_pct = 0;
            rcv_pct = 0;
         end else if (items >= 270) begin
            snd_pct = 75;
            rcv_pct = 32;
         end
         order = $urandom_range(15);
         if (order[0]) write_reg(pum_pkg::REG_COUNT, ($urandom_range(9) == 0) ? 32'd0 :
                                 $urandom_range(1, 6) | ($urandom & 32'hFFFF_F800));
         write_reg(pum_pkg::REG_BOX_X, pick_box());
         write_reg(pum_pkg::REG_BOX_Y, pick_box());
         write_reg(pum_pkg::REG_BOX_Z, pick_box());
         if (!order[0]) write_reg(pum_pkg::REG_COUNT, $urandom_range(1, 6));
         n_eff = i_count_eff();
         write_reg(pum_pkg::REG_START, {16'($urandom), frame_now + 16'(order[1])});
         if (order[1]) begin
            for (int s = 0; s < n_eff; s++) send($urandom, $urandom, $urandom);
         end
         frames = $urandom_range(2, 6);
         for (int f = 0; f < frames; f++) begin
            if (items >= 400 && items < 410 && f == 1) begin
               req_ch.valid <= 1'b0;
               @(posedge clock);
               while (pending != 0) @(posedge clock);
            end
            for (int s = 0; s < n_eff; s++) begin
               for (int a = 0; a < 3; a++)
                  walk[a][s] = (f == 0 && $urandom_range(1)) ? longint'($signed($urandom)) :
                               step_pos(walk[a][s], side_w[a]);
               send(walk[0][s][31:0], walk[1][s][31:0], walk[2][s][31:0]);
            end
         end
      end

      // a start frame that is never reached, so the particle is ignored
      settle();
      write_reg(pum_pkg::REG_START, 32'd65535);
      send($urandom, $urandom, $urandom);
      req_ch.valid <= 1'b0;
      settle();

      if (fails == 0) begin
         $display("periodic_unwrap_msd_top_tb OK");
      end else begin
         $display("periodic_unwrap_msd_top_tb NOT OK");
      end
      $finish;
   end

   // particles per frame as the block sees the count register
   function automatic int i_count_eff();
      return (count_w < 1) ? 1 : (count_w > 1024) ? 1024 : count_w;
   endfunction

endmodule

// ===== periodic_unwrap_msd_top.f =====
+incdir+src
src/pum_pkg.sv
src/pum_if.sv
src/pum_div.sv
src/pum_mem.sv
src/periodic_unwrap_msd_top.sv
sim/periodic_unwrap_msd_checker.sv
sim/periodic_unwrap_msd_top_tb.sv
